// ----- src/assert_macros.svh -----
// Assertion macros used by the lfu slot replacement back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define LFU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define LFU_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define LFU_ASSERT(lbl, prop, msg)

`define LFU_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

// ----- src/lfu_pkg.sv -----
// Shared types and constants for the lfu slot replacement unit.
package lfu_pkg;

  localparam int ID_W            = 7;
  localparam int CFG_W           = 6;
  localparam int SLOTS_DEF       = 32;
  localparam int ID_RANGE_DEF    = 128;
  localparam int COUNT_BITS_DEF  = 16;
  localparam logic [CFG_W-1:0] FRAMES_RESET = 6'd32;

  localparam logic KIND_VOTE   = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef struct packed {
    logic            kind;
    logic [ID_W-1:0] candidate_id;
  } in_word_t;

  typedef struct packed {
    logic [ID_W-1:0] id_out;
    logic            id_valid;
    logic            was_present;
    logic            last;
  } out_word_t;

  typedef enum logic [1:0] {
    OP_VOTE,
    OP_IGNORE,
    OP_REPORT
  } op_e;

  typedef struct packed {
    op_e             op;
    logic [ID_W-1:0] id;
  } cmd_t;

endpackage

// ----- src/lfu_front.sv -----
// Front end: accept and classify input words into a two-entry command queue.
module lfu_front
  import lfu_pkg::*;
#(
  parameter int ID_RANGE = ID_RANGE_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_word_t in_word_i,
  output logic     cmd_valid_o,
  input  logic     cmd_ready_i,
  output cmd_t     cmd_o
);

  cmd_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;
  cmd_t       cmd_new;

  always_comb begin
    cmd_new.id = in_word_i.candidate_id;
    if (in_word_i.kind == KIND_REPORT) begin
      cmd_new.op = OP_REPORT;
    end else if (32'(in_word_i.candidate_id) >= 32'(ID_RANGE)) begin
      cmd_new.op = OP_IGNORE;
    end else begin
      cmd_new.op = OP_VOTE;
    end
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cmd_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      unique case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ----- src/lfu_back.sv -----
// Back end: slot store, match, eviction scan, close-up and ascending report.
module lfu_back
  import lfu_pkg::*;
#(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int ID_RANGE   = ID_RANGE_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             cmd_valid_i,
  output logic             cmd_ready_o,
  input  cmd_t             cmd_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_word_t        out_word_o
);

  `include "assert_macros.svh"

  localparam int OCC_W    = $clog2(SLOTS + 1);
  localparam int IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int LIM_W    = ((OCC_W > CFG_W) ? OCC_W : CFG_W) + 1;
  localparam int ID_SPAN  = (ID_RANGE < (1 << ID_W)) ? ID_RANGE : (1 << ID_W);
  localparam int IDB_W    = $clog2(ID_SPAN);
  localparam int NCH      = (ID_SPAN + 7) / 8;
  localparam int CH_W     = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int PAD_W    = NCH * 8;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_SHIFT,
    S_REPORT
  } state_e;

  state_e                 state_q;
  cmd_t                   cmd_q;
  logic [ID_W-1:0]        ident_q [SLOTS];
  logic [COUNT_BITS-1:0]  uses_q  [SLOTS];
  logic [ID_W-1:0]        ident_up [SLOTS];
  logic [COUNT_BITS-1:0]  uses_up  [SLOTS];
  logic [OCC_W-1:0]       occ_q;
  logic [CFG_W-1:0]       frames_q;
  logic [ID_SPAN-1:0]     bitmap_q;
  logic [7:0]             shadow_q [NCH];
  logic [CH_W-1:0]        chunk_q;
  logic [OCC_W-1:0]       emit_q;
  logic [OCC_W-1:0]       scan_q;
  logic [IDX_W-1:0]       pick_q;
  logic [COUNT_BITS-1:0]  min_q;
  logic [ID_W-1:0]        gone_q;
  logic                   out_valid_q;
  out_word_t              out_word_q;

  logic [SLOTS-1:0]       match;
  logic                   hit;
  logic [LIM_W-1:0]       lim;
  logic                   need_evict;
  logic                   out_free;
  logic                   word_load;
  logic                   do_inc, do_append, do_shift;
  logic [PAD_W-1:0]       bitmap_pad;
  logic [7:0]             chunk_bits;
  logic [2:0]             low_b;
  logic [ID_W-1:0]        scan_id;
  logic [COUNT_BITS-1:0]  scan_uses;
  logic [OCC_W-1:0]       occ_dec;

  assign out_free    = !out_valid_q || out_ready_i;
  assign cmd_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;
  assign occ_dec     = occ_q - OCC_W'(1);

  always_comb begin
    if (frames_q == '0) begin
      lim = LIM_W'(1);
    end else if (LIM_W'(frames_q) > LIM_W'(SLOTS)) begin
      lim = LIM_W'(SLOTS);
    end else begin
      lim = LIM_W'(frames_q);
    end
  end

  assign need_evict = (LIM_W'(occ_q) >= lim) && (occ_q != '0);

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      match[i] = (OCC_W'(i) < occ_q) && (ident_q[i] == cmd_q.id);
    end
  end

  assign hit       = |match;
  assign scan_id   = ident_q[scan_q[IDX_W-1:0]];
  assign scan_uses = uses_q[scan_q[IDX_W-1:0]];

  assign do_inc    = (state_q == S_EXEC) && out_free && (cmd_q.op == OP_VOTE) && hit;
  assign do_append = (state_q == S_EXEC) && out_free && (cmd_q.op == OP_VOTE) && !hit &&
                     !need_evict;
  assign do_shift  = (state_q == S_SHIFT) && out_free;

  assign bitmap_pad = PAD_W'(bitmap_q);
  assign chunk_bits = shadow_q[chunk_q];

  assign word_load = out_free &&
                     (((state_q == S_EXEC) &&
                       !((cmd_q.op == OP_REPORT) && (occ_q != '0)) &&
                       !((cmd_q.op == OP_VOTE) && !hit && need_evict)) ||
                      (state_q == S_SHIFT) ||
                      ((state_q == S_REPORT) && (chunk_bits != 8'd0)));

  always_comb begin
    low_b = 3'd0;
    for (int b = 7; b >= 0; b--) begin
      if (chunk_bits[b]) low_b = 3'(b);
    end
  end

  for (genvar g = 0; g < SLOTS; g++) begin : g_up
    if (g < SLOTS - 1) begin : g_next
      assign ident_up[g] = ident_q[g+1];
      assign uses_up[g]  = uses_q[g+1];
    end else begin : g_tail
      assign ident_up[g] = '0;
      assign uses_up[g]  = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < SLOTS; i++) begin
      if (do_inc && match[i] && (uses_q[i] != COUNT_MAX)) begin
        uses_q[i] <= uses_q[i] + COUNT_BITS'(1);
      end
      if (do_append && (OCC_W'(i) == occ_q)) begin
        ident_q[i] <= cmd_q.id;
        uses_q[i]  <= COUNT_BITS'(1);
      end
      if (do_shift) begin
        if (OCC_W'(i) == occ_dec) begin
          ident_q[i] <= cmd_q.id;
          uses_q[i]  <= COUNT_BITS'(1);
        end else if ((IDX_W'(i) >= pick_q) && (OCC_W'(i) < occ_dec)) begin
          ident_q[i] <= ident_up[i];
          uses_q[i]  <= uses_up[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmd_q       <= '0;
      occ_q       <= '0;
      frames_q    <= FRAMES_RESET;
      bitmap_q    <= '0;
      for (int c = 0; c < NCH; c++) shadow_q[c] <= '0;
      chunk_q     <= '0;
      emit_q      <= '0;
      scan_q      <= '0;
      pick_q      <= '0;
      min_q       <= '0;
      gone_q      <= '0;
      out_valid_q <= 1'b0;
      out_word_q  <= '0;
    end else begin
      if (cfg_we_i) frames_q <= cfg_wdata_i;
      if (word_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            cmd_q   <= cmd_i;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (out_free) begin
            unique case (cmd_q.op)
              OP_REPORT: begin
                if (occ_q == '0) begin
                  out_word_q  <= '{id_out: '0, id_valid: 1'b0, was_present: 1'b0,
                                   last: 1'b1};
                  state_q     <= S_IDLE;
                end else begin
                  for (int c = 0; c < NCH; c++) shadow_q[c] <= bitmap_pad[c*8 +: 8];
                  chunk_q <= '0;
                  emit_q  <= '0;
                  state_q <= S_REPORT;
                end
              end
              OP_VOTE: begin
                if (hit) begin
                  out_word_q  <= '{id_out: '0, id_valid: 1'b0, was_present: 1'b1,
                                   last: 1'b1};
                  state_q     <= S_IDLE;
                end else if (need_evict) begin
                  scan_q  <= '0;
                  state_q <= S_SCAN;
                end else begin
                  occ_q       <= occ_q + OCC_W'(1);
                  bitmap_q[cmd_q.id[IDB_W-1:0]] <= 1'b1;
                  out_word_q  <= '{id_out: '0, id_valid: 1'b0, was_present: 1'b0,
                                   last: 1'b1};
                  state_q     <= S_IDLE;
                end
              end
              default: begin
                out_word_q  <= '{id_out: '0, id_valid: 1'b0, was_present: 1'b0,
                                 last: 1'b1};
                state_q     <= S_IDLE;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (scan_q == occ_q) begin
            state_q <= S_SHIFT;
          end else begin
            if ((scan_q == '0) || (scan_uses < min_q)) begin
              min_q  <= scan_uses;
              pick_q <= scan_q[IDX_W-1:0];
              gone_q <= scan_id;
            end
            scan_q <= scan_q + OCC_W'(1);
          end
        end
        S_SHIFT: begin
          if (out_free) begin
            bitmap_q    <= (bitmap_q & ~(ID_SPAN'(1) << gone_q[IDB_W-1:0])) |
                           (ID_SPAN'(1) << cmd_q.id[IDB_W-1:0]);
            out_word_q  <= '{id_out: gone_q, id_valid: 1'b1, was_present: 1'b0,
                             last: 1'b1};
            state_q     <= S_IDLE;
          end
        end
        S_REPORT: begin
          if (out_free) begin
            if (chunk_bits != 8'd0) begin
              shadow_q[chunk_q][low_b] <= 1'b0;
              emit_q      <= emit_q + OCC_W'(1);
              out_word_q  <= '{id_out: ID_W'({chunk_q, low_b}), id_valid: 1'b1,
                               was_present: 1'b0,
                               last: (emit_q + OCC_W'(1)) == occ_q};
              if ((emit_q + OCC_W'(1)) == occ_q) state_q <= S_IDLE;
            end else begin
              chunk_q <= chunk_q + CH_W'(1);
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `LFU_ASSERT(a_occ_bound, occ_q <= OCC_W'(SLOTS), "occupancy above slot count")
  `LFU_ASSERT(a_map_sync, 32'($countones(bitmap_q)) == 32'(occ_q), "id map out of step")
  `LFU_ASSERT(a_evict_keep, do_shift |=> occ_q == $past(occ_q), "evict changed occupancy")
  `LFU_ASSERT_NEVER(a_emit_bound, (state_q == S_REPORT) && (emit_q >= occ_q), "report overrun")

endmodule

// ----- src/lfu_slot_replacement_unit.sv -----
// Top level of the lfu slot replacement unit: front queue and back engine.
//
// Input channel (in_valid_i/in_ready_o, in_word_i) takes one word per item:
// a vote for candidate_id or a report request. Output channel
// (out_valid_o/out_ready_i, out_word_o) gives one word per vote and one word
// per held id for a report (one word if none are held), ascending, with last on the final word.
// cfg_we_i/cfg_wdata_i write frames_in_use at once; the user must write only while idle, the block does not enforce it.
// A vote that hits, misses without eviction or carries an invalid id passes
// through the queue and the command register to the output register; the
// engine takes a new command only when idle, so one finishes before the next.
// A vote that evicts walks the slots one per cycle on a single read port to
// find the minimum count, a last scan step ends the walk, then the shift state
// closes the gap and appends once the output is free. A report walks the
// held-id map in 8-id chunks, ascending: a step emits one id or skips a chunk.
// A two-entry queue parts the input side from the back engine, and the
// output register holds a word until taken; a stalled receiver halts the
// engine but the queue still fills.
// Reset empties all slots and sets frames_in_use to 32; no clearing pass.
module lfu_slot_replacement_unit
  import lfu_pkg::*;
#(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int ID_RANGE   = ID_RANGE_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_word_t         in_word_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_word_t        out_word_o
);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  lfu_front #(
    .ID_RANGE (ID_RANGE)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  lfu_back #(
    .SLOTS      (SLOTS),
    .ID_RANGE   (ID_RANGE),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

// ----- tb/lfu_slot_replacement_unit_test.sv -----
// Testbench for the lfu slot replacement unit: words checked against a frame predictor.
module lfu_slot_replacement_unit_test;
  import lfu_pkg::*;

  localparam int SLOT_CNT      = SLOTS_DEF;
  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 100;
  localparam int MAX_SHOWN     = 10;
  localparam int PHASE_WORDS   = 60;

  logic             clk;
  logic             rst_n     = 1'b0;
  logic             cfg_we    = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  in_word_t         in_word   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_word_t        out_word;

  logic [ID_W-1:0]           held_id   [SLOT_CNT];
  logic [COUNT_BITS_DEF-1:0] held_uses [SLOT_CNT];
  int                        held_n     = 0;
  logic [CFG_W-1:0]          frames_cfg = FRAMES_RESET;
  out_word_t                 awaited_words[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatches     = 0;
  int quiet_cycles   = 0;

  lfu_slot_replacement_unit u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic in_word_t vote_word(logic [ID_W-1:0] id);
    return {KIND_VOTE, id};
  endfunction

  function automatic in_word_t report_word(logic [ID_W-1:0] junk);
    return {KIND_REPORT, junk};
  endfunction

  function automatic void queue_word(out_word_t r);
    awaited_words = {awaited_words, r};
  endfunction

  // Advance the predicted frame by one accepted word and queue the words it yields.
  function automatic void frame_step(in_word_t w);
    out_word_t       r;
    int              lim;
    int              pick;
    logic [ID_W-1:0] sorted[$];
    r      = '0;
    r.last = 1'b1;
    if (w.kind == KIND_REPORT) begin
      if (held_n == 0) begin
        queue_word(r);
        return;
      end
      for (int i = 0; i < held_n; i++) sorted = {sorted, held_id[i]};
      sorted.sort();
      foreach (sorted[i]) begin
        r.id_out   = sorted[i];
        r.id_valid = 1'b1;
        r.last     = (i == sorted.size() - 1);
        queue_word(r);
      end
      return;
    end
    if (int'(w.candidate_id) >= ID_RANGE_DEF) begin
      queue_word(r);
      return;
    end
    for (int i = 0; i < held_n; i++) begin
      if (held_id[i] == w.candidate_id) begin
        if (held_uses[i] != '1) held_uses[i]++;
        r.was_present = 1'b1;
        queue_word(r);
        return;
      end
    end
    lim = (frames_cfg == 0) ? 1 : (int'(frames_cfg) > SLOT_CNT) ? SLOT_CNT : int'(frames_cfg);
    if (held_n + 1 > lim && held_n > 0) begin
      pick = 0;
      for (int i = 1; i < held_n; i++) if (held_uses[i] < held_uses[pick]) pick = i;
      r.id_out   = held_id[pick];
      r.id_valid = 1'b1;
      for (int i = pick; i + 1 < held_n; i++) begin
        held_id[i]   = held_id[i + 1];
        held_uses[i] = held_uses[i + 1];
      end
      held_n--;
    end
    if (held_n < SLOT_CNT) begin
      held_id[held_n]   = w.candidate_id;
      held_uses[held_n] = COUNT_BITS_DEF'(1);
      held_n++;
    end
    queue_word(r);
  endfunction

  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    frame_step(w);
  endtask

  // Hold the sender until every queued word has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (awaited_words.size() != 0) @(posedge clk);
  endtask

  task automatic set_frames(input logic [CFG_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we     <= 1'b0;
    frames_cfg = v;
  endtask

  task automatic test_empty_report();
    send_word(report_word(7'h7F));
    send_word(report_word(7'h00));
    wait_drained();
  endtask

  task automatic test_repeat_hits();
    set_frames(6'd2);
    repeat (12) send_word(vote_word(7'h11));
    repeat (10) send_word(vote_word(7'h22));
    send_word(vote_word(7'h33));
    send_word(vote_word(7'h44));
    wait_drained();
  endtask

  task automatic test_directed_cases();
    set_frames(6'd0);
    send_word(vote_word(7'h7F));
    send_word(vote_word(7'h00));
    send_word(report_word(7'h55));
    wait_drained();
    set_frames(6'd63);
    send_word(vote_word(7'h00));
    send_word(vote_word(7'h55));
    send_word(vote_word(7'h2A));
    send_word(vote_word(7'h55));
    send_word(vote_word(7'h2A));
    send_word(vote_word(7'h01));
    send_word(report_word(7'h2A));
    wait_drained();
    set_frames(6'd6);
    send_word(vote_word(7'h02));
    send_word(vote_word(7'h03));
    send_word(vote_word(7'h04));
    send_word(report_word(7'h00));
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int       roll;
    in_word_t w;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          set_frames(6'd1);
        end
        1: begin
          send_idle_pct  = 78;
          recv_stall_pct = 0;
          set_frames(6'd12);
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 78;
          set_frames(6'd33);
        end
        default: begin
          send_idle_pct  = 31;
          recv_stall_pct = 31;
          set_frames(CFG_W'($urandom_range(63)));
        end
      endcase
      repeat (PHASE_WORDS) begin
        roll = $urandom_range(99);
        if (roll < 8) w = report_word(ID_W'($urandom));
        else if (roll < 55 && held_n > 0) w = vote_word(held_id[$urandom_range(held_n - 1)]);
        else if (roll < 85) w = vote_word(ID_W'($urandom_range(40)));
        else w = vote_word(ID_W'($urandom));
        send_word(w);
      end
      wait_drained();
    end
  endtask

  task automatic test_limit_lowered();
    send_idle_pct  = 31;
    recv_stall_pct = 31;
    set_frames(6'd32);
    while (held_n < SLOT_CNT) send_word(vote_word(ID_W'($urandom)));
    wait_drained();
    set_frames(6'd3);
    repeat (6) send_word(vote_word(ID_W'($urandom)));
    repeat (4) send_word(vote_word(held_id[$urandom_range(held_n - 1)]));
    send_word(report_word(ID_W'($urandom)));
    wait_drained();
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n) begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
      if (out_valid && out_ready) begin
        if (awaited_words.size() == 0) begin
          if (mismatches < MAX_SHOWN)
            $display("unexpected word: id %0d valid %0b present %0b last %0b",
                     out_word.id_out, out_word.id_valid, out_word.was_present,
                     out_word.last);
          mismatches++;
        end else begin
          want = awaited_words.pop_front();
          if (out_word.id_out !== want.id_out || out_word.id_valid !== want.id_valid ||
              out_word.was_present !== want.was_present || out_word.last !== want.last) begin
            if (mismatches < MAX_SHOWN)
              $display({"mismatch: expected id %0d valid %0b present %0b last %0b, ",
                        "got id %0d valid %0b present %0b last %0b"},
                       want.id_out, want.id_valid, want.was_present, want.last,
                       out_word.id_out, out_word.id_valid, out_word.was_present,
                       out_word.last);
            mismatches++;
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_report();
    test_repeat_hits();
    test_directed_cases();
    test_random_traffic();
    test_limit_lowered();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && awaited_words.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
